/* hdl/tbi_pkg.sv */
// Package for the toy bytecode interpreter step block.
// Holds request/result structs, opcode kinds, status codes and decode tables.
// No dependencies.
package tbi_pkg;

    localparam int BlockBytes = 256;
    localparam int RegCount   = 16;
    localparam int ArrayBytes = 128;

    typedef struct packed {
        logic       command;
        logic [7:0] code_byte0;
        logic [7:0] code_byte1;
        logic [7:0] code_byte2;
        logic [4:0] button_bits;
        logic       sound_busy;
        logic [7:0] random_byte;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] next_block;
        logic [8:0] next_offset;
        logic       led_write;
        logic [2:0] led_number;
        logic       led_on;
        logic       sound_start;
        logic [7:0] sound_number;
    } t_res;

    localparam logic [2:0] ST_EXEC  = 3'd0;
    localparam logic [2:0] ST_YIELD = 3'd1;
    localparam logic [2:0] ST_JUMP  = 3'd2;
    localparam logic [2:0] ST_RETRY = 3'd3;
    localparam logic [2:0] ST_ERROR = 3'd4;

    typedef enum logic [4:0] {
        K_BAD, K_SET, K_ADD, K_SUB, K_MUL, K_DIV, K_AND, K_OR, K_XOR, K_LON,
        K_LOFF, K_SND, K_SNDB, K_INPUT, K_DELAY, K_LOAD, K_STORE, K_JMP,
        K_JEQ, K_JGT, K_RAND
    } t_kind;

    // decoded instruction passed from front to back
    typedef struct packed {
        t_req       req;
        t_kind      kind;
        logic       len_err;    // set for an opcode that does not decode
        logic [1:0] len;        // instruction length in bytes
        logic [3:0] p1;
        logic [3:0] p2;
        logic [3:0] p3;
        logic [7:0] imm;
    } t_dec;

    function automatic t_kind short_op(input logic [3:0] n);
        case (n)
            4'h1: short_op = K_SET;
            4'h2: short_op = K_LON;
            4'h3: short_op = K_LOFF;
            4'h4: short_op = K_SND;
            4'h5: short_op = K_SNDB;
            4'h6: short_op = K_DELAY;
            4'h7: short_op = K_JMP;
            4'h8: short_op = K_JEQ;
            4'h9: short_op = K_JGT;
            default: short_op = K_BAD;
        endcase
    endfunction

    function automatic t_kind medium_op(input logic [3:0] n);
        case (n)
            4'h1: medium_op = K_INPUT;
            4'h2: medium_op = K_LOAD;
            4'h3: medium_op = K_STORE;
            4'h4: medium_op = K_RAND;
            default: medium_op = K_BAD;
        endcase
    endfunction

    function automatic t_kind long_op(input logic [3:0] n);
        case (n)
            4'h1: long_op = K_ADD;
            4'h2: long_op = K_SUB;
            4'h3: long_op = K_MUL;
            4'h4: long_op = K_DIV;
            4'h5: long_op = K_AND;
            4'h6: long_op = K_OR;
            4'h7: long_op = K_XOR;
            default: long_op = K_BAD;
        endcase
    endfunction

endpackage

/* hdl/toy_bytecode_interpreter_step.sv */
// Each request passes the decode queue, then operand read, memory/multiply and
// result; a divide runs an eight-step restoring divider in place of memory.
// The back end works on one request at a time and takes no new one until idle.
// The two-entry decode queue accepts while the back end works.
// Reset (synchronous, active low) clears registers, state, queues and the
// data array's written marks, so the data array reads zero until written.
module toy_bytecode_interpreter_step import tbi_pkg::*; #(
    parameter int BLOCK_BYTES = BlockBytes,
    parameter int ARRAY_BYTES = ArrayBytes
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_req i_req,
    output logic empty,
    input  logic pop,
    output t_res o_res
);

    logic w_dv, w_take;
    t_dec w_dec;

    tbi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_req(i_req), .o_dec_valid(w_dv), .o_dec(w_dec), .i_dec_take(w_take)
    );

    tbi_back #(.BLOCK_BYTES(BLOCK_BYTES), .ARRAY_BYTES(ARRAY_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_dec_valid(w_dv), .i_dec(w_dec),
        .o_dec_take(w_take), .o_empty(empty), .i_pop(pop), .o_res(o_res)
    );

endmodule

/* hdl/tbi_front.sv */
// Front end: accepts requests, decodes opcode form and operands, and feeds
// a two-entry queue toward the back end. Depends on tbi_pkg.
module tbi_front import tbi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_req i_req,
    output logic o_dec_valid,
    output t_dec o_dec,
    input  logic i_dec_take
);

    t_dec       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_dec       w_dec;
    logic       w_push, w_pop;
    t_kind      w_k;
    logic [1:0] w_pos;
    logic [1:0] w_len;
    logic [7:0] w_pb;
    logic       w_err;

    // length checks against BLOCK_BYTES happen in the back end, which holds the
    // offset, so only byte counts are recorded here
    always_comb begin
        w_err = 1'b0;
        w_pos = 2'd0;
        if (i_req.code_byte0[7:4] != 4'h0) begin
            w_k   = short_op(i_req.code_byte0[7:4]);
            w_pos = 2'd0;
        end else if (i_req.code_byte0[3:0] != 4'h0) begin
            w_k   = medium_op(i_req.code_byte0[3:0]);
            w_pos = 2'd1;
        end else begin
            w_k   = long_op(i_req.code_byte1[7:4]);
            w_pos = 2'd1;
        end
        w_pb  = (w_pos == 2'd0) ? i_req.code_byte0 : i_req.code_byte1;
        w_dec = '0;
        w_dec.req  = i_req;
        w_dec.kind = w_k;
        w_dec.imm  = i_req.code_byte1;
        case (w_k)
            K_INPUT, K_LOAD, K_STORE, K_RAND: begin
                w_dec.p1 = w_pb[7:4];
                w_dec.p2 = w_pb[3:0];
                w_len    = 2'd2;
            end
            K_ADD, K_SUB, K_MUL, K_DIV, K_AND, K_OR, K_XOR: begin
                w_dec.p1 = i_req.code_byte1[3:0];
                w_dec.p2 = i_req.code_byte2[7:4];
                w_dec.p3 = i_req.code_byte2[3:0];
                w_len    = 2'd3;
            end
            K_JEQ, K_JGT: begin
                w_dec.p1 = i_req.code_byte0[3:0];
                w_dec.p2 = i_req.code_byte1[7:4];
                w_dec.p3 = i_req.code_byte1[3:0];
                w_len    = 2'd2;
            end
            K_SET: begin
                w_dec.p1 = i_req.code_byte0[3:0];
                w_len    = 2'd2;
            end
            K_BAD: begin
                // long form fetches byte 1 to decode; medium/short only byte 0
                w_len = (i_req.code_byte0 == 8'h00) ? 2'd2 : 2'd1;
                w_err = 1'b1;
            end
            default: begin
                w_dec.p1 = i_req.code_byte0[3:0];
                w_len    = 2'd1;
            end
        endcase
        w_dec.len     = w_len;
        w_dec.len_err = w_err;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_dec_take && (r_cnt != 2'd0);
    assign o_dec_valid = (r_cnt != 2'd0);
    assign o_dec       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> (r_cnt == 2'd2))
        else $error("full queue lost an entry");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop)
        else $error("pop from empty queue");

endmodule

/* hdl/tbi_back.sv */
// Back end: runs one decoded instruction over several cycles against the
// register file, data array and machine state; holds one result register.
// Depends on tbi_pkg.
module tbi_back import tbi_pkg::*; #(
    parameter int BLOCK_BYTES = BlockBytes,
    parameter int ARRAY_BYTES = ArrayBytes
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_dec_valid,
    input  t_dec i_dec,
    output logic o_dec_take,
    output logic o_empty,
    input  logic i_pop,
    output t_res o_res
);

    localparam int AW = (ARRAY_BYTES > 1) ? $clog2(ARRAY_BYTES) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_DIV  = 5'b00100,
        S_MEM  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state     r_st, n_st;
    logic [7:0] r_rf [16];
    logic [7:0] r_mem [ARRAY_BYTES];
    logic [ARRAY_BYTES-1:0] r_vld;
    logic [8:0] r_off;
    logic [7:0] r_dly;
    logic       r_wait;
    logic [3:0] r_wreg;
    logic       r_sblk;
    t_dec       r_d;
    logic [7:0] r_a, r_b, r_c;
    logic [7:0] r_rd;
    logic [7:0] r_quo;
    logic [8:0] r_rem;
    logic [3:0] r_dcnt;
    logic       r_full;
    t_res       r_res;

    logic       w_take;
    logic       w_pre_yield;
    logic       w_hold;
    logic [7:0] w_btn;
    logic [7:0] w_ra, w_rb, w_rc;
    logic [9:0] w_end;
    logic       w_oob;
    logic [7:0] w_lim, w_mask, w_rv;
    logic [8:0] w_shf;
    logic       w_ge;
    logic [8:0] w_sub;
    t_res       w_res;
    logic       w_commit;
    logic       w_wr_rf;
    logic [3:0] w_wr_idx;
    logic [7:0] w_wr_val;
    logic       w_idx_ok;

    assign o_empty    = !r_full;
    assign o_res      = r_res;
    assign w_take     = (r_st == S_IDLE) && i_dec_valid && (!r_full || i_pop);
    assign o_dec_take = w_take;
    assign w_btn      = {3'b000, r_d.req.button_bits};
    // a pending button wait writes the buttons before the operands are read
    assign w_ra       = (r_wait && r_wreg == r_d.p1) ? w_btn : r_rf[r_d.p1];
    assign w_rb       = (r_wait && r_wreg == r_d.p2) ? w_btn : r_rf[r_d.p2];
    assign w_rc       = (r_wait && r_wreg == r_d.p3) ? w_btn : r_rf[r_d.p3];
    assign w_end      = {1'b0, r_off} + {8'd0, r_d.len};
    assign w_oob      = (w_end > 10'(BLOCK_BYTES)) ||
                        ({1'b0, r_off} >= 10'(BLOCK_BYTES));
    assign w_idx_ok   = ({1'b0, r_b} < 9'(ARRAY_BYTES));
    assign w_lim      = r_b;
    assign w_shf      = {r_rem[7:0], r_quo[7]};
    assign w_ge       = (w_shf >= {1'b0, r_c});
    assign w_sub      = w_shf - {1'b0, r_c};
    assign w_hold     = !r_d.req.command &&
                        (w_res.status == ST_ERROR || w_res.status == ST_RETRY);

    always_comb begin
        w_mask = 8'hFF;
        if (w_lim <= 8'd128) begin
            w_mask = 8'h00;
            for (int i = 0; i < 8; i++) begin
                if ((8'd1 << i) < w_lim) w_mask[i] = 1'b1;
            end
        end
        w_rv = r_d.req.random_byte & w_mask;
    end

    // the wait/delay/sound prelude, evaluated with the current state
    always_comb begin
        w_pre_yield = 1'b0;
        if (r_wait) begin
            if (r_d.req.button_bits == 5'd0 && r_dly != 8'd0) w_pre_yield = 1'b1;
        end else if (r_dly != 8'd0) begin
            w_pre_yield = 1'b1;
        end
        if (r_sblk && r_d.req.sound_busy) w_pre_yield = 1'b1;
    end

    always_comb begin
        w_res    = '0;
        w_commit = 1'b0;
        w_wr_rf  = 1'b0;
        w_wr_idx = r_d.p1;
        w_wr_val = 8'd0;
        w_res.next_offset = r_off;
        w_res.status = ST_EXEC;
        if (r_d.req.command) begin
            w_res.status = ST_YIELD;
        end else if (w_pre_yield) begin
            w_res.status = ST_YIELD;
        end else if (w_oob || r_d.kind == K_BAD || r_d.len_err) begin
            w_res.status = ST_ERROR;
        end else begin
            w_commit = 1'b1;
            w_res.next_offset = w_end[8:0];
            case (r_d.kind)
                K_SET:   begin w_wr_rf = 1'b1; w_wr_val = r_d.imm; end
                K_ADD:   begin w_wr_rf = 1'b1; w_wr_val = r_b + r_c; end
                K_SUB:   begin w_wr_rf = 1'b1; w_wr_val = r_b - r_c; end
                K_MUL:   begin w_wr_rf = 1'b1; w_wr_val = r_rd; end
                K_DIV: begin
                    if (r_c == 8'd0) begin
                        w_commit = 1'b0;
                        w_res.status = ST_ERROR;
                        w_res.next_offset = r_off;
                    end else begin
                        w_wr_rf = 1'b1; w_wr_val = r_quo;
                    end
                end
                K_AND:   begin w_wr_rf = 1'b1; w_wr_val = r_b & r_c; end
                K_OR:    begin w_wr_rf = 1'b1; w_wr_val = r_b | r_c; end
                K_XOR:   begin w_wr_rf = 1'b1; w_wr_val = r_b ^ r_c; end
                K_LON, K_LOFF: begin
                    if (r_a < 8'd5) begin
                        w_res.led_write  = 1'b1;
                        w_res.led_number = r_a[2:0];
                        w_res.led_on     = (r_d.kind == K_LON);
                    end
                end
                K_SND, K_SNDB: begin
                    w_res.sound_start  = 1'b1;
                    w_res.sound_number = r_a;
                end
                K_INPUT: begin w_wr_rf = 1'b1; w_wr_val = w_btn; end
                K_DELAY: ;
                K_LOAD, K_STORE: begin
                    if (!w_idx_ok) begin
                        w_commit = 1'b0;
                        w_res.status = ST_ERROR;
                        w_res.next_offset = r_off;
                    end else if (r_d.kind == K_LOAD) begin
                        w_wr_rf = 1'b1; w_wr_val = r_rd;
                    end
                end
                K_JMP, K_JEQ, K_JGT: begin
                    if (r_d.kind == K_JMP || (r_d.kind == K_JEQ && r_a == r_b) ||
                        (r_d.kind == K_JGT && r_a > r_b)) begin
                        w_res.status      = ST_JUMP;
                        w_res.next_block  = (r_d.kind == K_JMP) ? r_a : r_c;
                        w_res.next_offset = 9'd0;
                    end
                end
                K_RAND: begin
                    if (w_rv > w_lim) begin
                        w_commit = 1'b0;
                        w_res.status = ST_RETRY;
                        w_res.next_offset = r_off;
                    end else begin
                        w_wr_rf = 1'b1; w_wr_val = w_rv;
                    end
                end
                default: begin
                    w_commit = 1'b0;
                    w_res.status = ST_ERROR;
                    w_res.next_offset = r_off;
                end
            endcase
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (w_take) n_st = S_READ;
            S_READ: n_st = (r_d.kind == K_DIV && w_rc != 8'd0) ? S_DIV : S_MEM;
            S_DIV:  if (r_dcnt == 4'd7) n_st = S_DONE;
            S_MEM:  n_st = S_DONE;
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // operand read into registers first; restoring divide, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (w_take) r_d <= i_dec;
        case (r_st)
            S_READ: begin
                r_a    <= w_ra;
                r_b    <= w_rb;
                r_c    <= w_rc;
                r_rem  <= 9'd0;
                r_quo  <= w_rb;
                r_dcnt <= 4'd0;
            end
            S_DIV: begin
                r_rem  <= w_ge ? w_sub : w_shf;
                r_quo  <= {r_quo[6:0], w_ge};
                r_dcnt <= r_dcnt + 4'd1;
            end
            S_MEM: begin
                r_rd <= (r_d.kind == K_MUL) ? 8'(r_b * r_c) :
                        (r_vld[r_b[AW-1:0]] ? r_mem[r_b[AW-1:0]] : 8'd0);
            end
            default: ;
        endcase
        if (r_st == S_DONE && w_commit && r_d.kind == K_STORE) begin
            r_mem[r_b[AW-1:0]] <= r_a;
        end
        if (r_st == S_DONE) r_res <= w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_full <= 1'b0;
            r_off  <= 9'd0;
            r_dly  <= 8'd0;
            r_wait <= 1'b0;
            r_wreg <= 4'd0;
            r_sblk <= 1'b0;
            r_vld  <= '0;
            for (int i = 0; i < 16; i++) r_rf[i] <= 8'd0;
        end else begin
            r_st <= n_st;
            if (r_st == S_DONE) begin
                r_full <= 1'b1;
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
            if (r_st == S_DONE) begin
                if (r_d.req.command) begin
                    if (r_dly != 8'd0) r_dly <= r_dly - 8'd1;
                end else if (!w_hold) begin
                    if (r_wait) begin
                        r_rf[r_wreg] <= w_btn;
                        if (r_d.req.button_bits != 5'd0) begin
                            r_wait <= 1'b0;
                            r_dly  <= 8'd0;
                        end else if (r_dly == 8'd0) begin
                            r_wait <= 1'b0;
                        end
                    end
                    if (!w_pre_yield) r_sblk <= 1'b0;
                    if (w_commit) begin
                        r_off <= w_res.next_offset;
                        if (w_wr_rf) r_rf[w_wr_idx] <= w_wr_val;
                        if (r_d.kind == K_SNDB) r_sblk <= 1'b1;
                        if (r_d.kind == K_DELAY) r_dly <= r_a;
                        if (r_d.kind == K_STORE) r_vld[r_b[AW-1:0]] <= 1'b1;
                        if (r_d.kind == K_INPUT && r_d.req.button_bits == 5'd0) begin
                            // delay register is read after the buttons are written
                            if (r_d.p1 == r_d.p2) begin
                                r_dly <= 8'd0;
                            end else begin
                                r_dly <= r_b;
                                if (r_b != 8'd0) begin
                                    r_wait <= 1'b1;
                                    r_wreg <= r_d.p1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DONE) |=> r_full)
        else $error("result lost at completion");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (r_st == S_IDLE))
        else $error("request taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DIV) |-> (r_dcnt < 4'd8))
        else $error("divider overran");

endmodule

/* tb/sv/toy_bytecode_interpreter_step_chk.sv */
`timescale 1ns / 1ps
// Step checker for the toy bytecode interpreter: predicts each result from
// the accepted requests and compares it with what the block returns.
// Depends on tbi_pkg.
module toy_bytecode_interpreter_step_chk import tbi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_full,
    input  t_req i_req,
    input  logic i_empty,
    input  logic i_pop,
    input  t_res i_res,
    output int   o_errors,
    output int   o_pending
);

    logic [7:0] regs [RegCount];
    logic [7:0] darr [ArrayBytes];
    logic [8:0] cur_off;
    logic [7:0] dly;
    logic       waiting;
    logic [3:0] wait_reg;
    logic       snd_block;
    t_res       step_q [$];

    function automatic logic [2:0] run_instr(input t_req q, inout t_res r);
        logic [7:0] b [3];
        int unsigned pos;
        logic [3:0] p1, p2, p3;
        t_kind kind;
        logic [7:0] lim, mask, v;
        int unsigned span;
        logic take;
        b[0] = q.code_byte0;
        b[1] = q.code_byte1;
        b[2] = q.code_byte2;
        pos = 0;
        p1 = '0;
        p2 = '0;
        p3 = '0;
        if (waiting) begin
            regs[wait_reg] = {3'b0, q.button_bits};
            if (q.button_bits != 0) begin
                waiting = 1'b0;
                dly = '0;
            end else if (dly != 0) begin
                return ST_YIELD;
            end else begin
                waiting = 1'b0;
            end
        end else if (dly != 0) begin
            return ST_YIELD;
        end
        if (snd_block && q.sound_busy) return ST_YIELD;
        snd_block = 1'b0;
        if (cur_off >= BlockBytes) return ST_ERROR;
        if (b[0][7:4] != 0) begin
            case (b[0][7:4])
                4'h1: kind = K_SET;
                4'h2: kind = K_LON;
                4'h3: kind = K_LOFF;
                4'h4: kind = K_SND;
                4'h5: kind = K_SNDB;
                4'h6: kind = K_DELAY;
                4'h7: kind = K_JMP;
                4'h8: kind = K_JEQ;
                4'h9: kind = K_JGT;
                default: kind = K_BAD;
            endcase
        end else if (b[0][3:0] != 0) begin
            case (b[0][3:0])
                4'h1: kind = K_INPUT;
                4'h2: kind = K_LOAD;
                4'h3: kind = K_STORE;
                4'h4: kind = K_RAND;
                default: kind = K_BAD;
            endcase
            pos = 1;
        end else begin
            if (cur_off + 1 >= BlockBytes) return ST_ERROR;
            case (b[1][7:4])
                4'h1: kind = K_ADD;
                4'h2: kind = K_SUB;
                4'h3: kind = K_MUL;
                4'h4: kind = K_DIV;
                4'h5: kind = K_AND;
                4'h6: kind = K_OR;
                4'h7: kind = K_XOR;
                default: kind = K_BAD;
            endcase
            pos = 1;
        end
        if (kind == K_BAD) return ST_ERROR;
        if (kind inside {K_INPUT, K_LOAD, K_STORE, K_RAND}) begin
            if (cur_off + pos >= BlockBytes) return ST_ERROR;
            p1 = b[pos][7:4];
            p2 = b[pos][3:0];
            pos++;
        end else begin
            p1 = b[pos][3:0];
            pos++;
            if (kind inside {K_ADD, K_SUB, K_MUL, K_DIV, K_AND, K_OR, K_XOR,
                             K_JEQ, K_JGT}) begin
                if (cur_off + pos >= BlockBytes) return ST_ERROR;
                p2 = b[pos][7:4];
                p3 = b[pos][3:0];
                pos++;
            end
        end
        case (kind)
            K_SET: begin
                if (cur_off + pos >= BlockBytes) return ST_ERROR;
                regs[p1] = b[pos];
                pos++;
            end
            K_ADD: regs[p1] = regs[p2] + regs[p3];
            K_SUB: regs[p1] = regs[p2] - regs[p3];
            K_MUL: regs[p1] = regs[p2] * regs[p3];
            K_DIV: begin
                if (regs[p3] == 0) return ST_ERROR;
                regs[p1] = regs[p2] / regs[p3];
            end
            K_AND: regs[p1] = regs[p2] & regs[p3];
            K_OR:  regs[p1] = regs[p2] | regs[p3];
            K_XOR: regs[p1] = regs[p2] ^ regs[p3];
            K_LON, K_LOFF: begin
                if (regs[p1] < 5) begin
                    r.led_write  = 1'b1;
                    r.led_number = regs[p1][2:0];
                    r.led_on     = (kind == K_LON);
                end
            end
            K_SND, K_SNDB: begin
                if (kind == K_SNDB) snd_block = 1'b1;
                r.sound_start  = 1'b1;
                r.sound_number = regs[p1];
            end
            K_INPUT: begin
                regs[p1] = {3'b0, q.button_bits};
                if (q.button_bits == 0) begin
                    dly = regs[p2];
                    if (dly != 0) begin
                        waiting  = 1'b1;
                        wait_reg = p1;
                    end
                end
            end
            K_DELAY: dly = regs[p1];
            K_LOAD: begin
                if (regs[p2] >= ArrayBytes) return ST_ERROR;
                regs[p1] = darr[regs[p2]];
            end
            K_STORE: begin
                if (regs[p2] >= ArrayBytes) return ST_ERROR;
                darr[regs[p2]] = regs[p1];
            end
            K_JMP, K_JEQ, K_JGT: begin
                take = (kind == K_JMP) || (kind == K_JEQ && regs[p1] == regs[p2]) ||
                       (kind == K_JGT && regs[p1] > regs[p2]);
                if (take) begin
                    r.next_block = (kind == K_JMP) ? regs[p1] : regs[p3];
                    cur_off = '0;
                    return ST_JUMP;
                end
            end
            K_RAND: begin
                lim = regs[p2];
                if (lim > 128) begin
                    mask = 8'hFF;
                end else begin
                    span = 1;
                    while (span < lim) span = span << 1;
                    mask = 8'(span - 1);
                end
                v = q.random_byte & mask;
                if (v > lim) return ST_RETRY;
                regs[p1] = v;
            end
            default: return ST_ERROR;
        endcase
        cur_off = 9'(cur_off + pos);
        return ST_EXEC;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            foreach (regs[i]) regs[i] = '0;
            foreach (darr[i]) darr[i] = '0;
            cur_off   = '0;
            dly       = '0;
            waiting   = 1'b0;
            wait_reg  = '0;
            snd_block = 1'b0;
            step_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (step_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, i_res);
                    o_errors <= o_errors + 1;
                end else begin
                    want = step_q.pop_front();
                    if (i_res !== want) begin
                        $display("%0t: result wrong, expected %p, actual %p",
                                 $time, want, i_res);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_push && !i_full) begin
                step_q.push_back(predict_step_fix(i_req));
            end
            o_pending <= step_q.size();
        end
    end

    function automatic t_res predict_step_fix(input t_req q);
        t_res r;
        logic [2:0] st;
        logic [7:0] s_regs [RegCount];
        logic [7:0] s_darr [ArrayBytes];
        logic [8:0] s_off;
        logic [7:0] s_dly;
        logic       s_wait, s_sndb;
        logic [3:0] s_wreg;
        r = '0;
        if (q.command) begin
            if (dly != 0) dly--;
            st = ST_YIELD;
        end else begin
            s_regs = regs;
            s_darr = darr;
            s_off  = cur_off;
            s_dly  = dly;
            s_wait = waiting;
            s_wreg = wait_reg;
            s_sndb = snd_block;
            st = run_instr(q, r);
            if (st == ST_ERROR || st == ST_RETRY) begin
                regs      = s_regs;
                darr      = s_darr;
                cur_off   = s_off;
                dly       = s_dly;
                waiting   = s_wait;
                wait_reg  = s_wreg;
                snd_block = s_sndb;
                r = '0;
            end
        end
        r.status      = st;
        r.next_offset = cur_off;
        return r;
    endfunction

endmodule

/* tb/sv/toy_bytecode_interpreter_step_tb.sv */
`timescale 1ns / 1ps
// Top of the toy bytecode interpreter step testbench: clock, reset, request
// stimulus, result drain and verdict. Depends on tbi_pkg, the block and
// toy_bytecode_interpreter_step_chk.
module toy_bytecode_interpreter_step_tb;
    import tbi_pkg::*;

    localparam int StallLimit = 5000;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_req i_req;
    logic empty;
    logic pop;
    t_res o_res;
    int   errors;
    int   pending;
    int   tx_idle;
    int   rx_idle;
    int   quiet_cycles;

    toy_bytecode_interpreter_step uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    toy_bytecode_interpreter_step_chk chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_req     (i_req),
        .i_empty   (empty),
        .i_pop     (pop),
        .i_res     (o_res),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("toy_bytecode_interpreter_step: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input logic cmd, input logic [7:0] b0, input logic [7:0] b1,
                        input logic [7:0] b2, input logic [4:0] btn, input logic busy,
                        input logic [7:0] rnd);
        logic ok;
        while ($urandom_range(99) < tx_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= '{cmd, b0, b1, b2, btn, busy, rnd};
        do begin
            @(negedge i_clk);
            ok = !full;
            @(posedge i_clk);
        end while (!ok);
    endtask

    task automatic exec(input logic [7:0] b0, input logic [7:0] b1 = 8'h00,
                        input logic [7:0] b2 = 8'h00, input logic [4:0] btn = 5'h01,
                        input logic busy = 1'b0, input logic [7:0] rnd = 8'h00);
        send(1'b0, b0, b1, b2, btn, busy, rnd);
    endtask

    task automatic tick();
        send(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom),
             1'($urandom), 8'($urandom));
    endtask

    // one random instruction; opcode nibbles as decoded by the block
    task automatic random_instr();
        logic [3:0] a, b, c;
        logic [7:0] imm, b0, b1, b2;
        logic [4:0] btn;
        int sel;
        a   = 4'($urandom);
        b   = 4'($urandom);
        c   = 4'($urandom);
        imm = ($urandom_range(99) < 60) ? 8'($urandom_range(7)) : 8'($urandom);
        btn = ($urandom_range(3) == 0) ? 5'h00 : 5'($urandom);
        b2  = 8'($urandom);
        sel = $urandom_range(23);
        if (sel < 9) begin
            b0 = {4'(sel + 1), a};
            b1 = (sel == 0) ? imm : {b, c};
        end else if (sel < 13) begin
            b0 = {4'h0, 4'(sel - 8)};
            b1 = {a, b};
        end else if (sel < 20) begin
            b0 = 8'h00;
            b1 = {4'(sel - 12), a};
            b2 = {b, c};
        end else if (sel == 20) begin
            b0 = {4'($urandom_range(15, 10)), a};
            b1 = 8'($urandom);
        end else if (sel == 21) begin
            b0 = {4'h0, 4'($urandom_range(15, 5))};
            b1 = 8'($urandom);
        end else if (sel == 22) begin
            b0 = 8'h00;
            b1 = ($urandom_range(1) == 0) ? {4'h0, a} : {4'($urandom_range(15, 8)), a};
        end else begin
            b0 = {4'h7, a};
            b1 = 8'($urandom);
        end
        exec(b0, b1, b2, btn, 1'($urandom), 8'($urandom));
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        i_req   = '0;
        tx_idle = 34;
        rx_idle = 73;
        quiet_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        exec(8'h12, 8'h05);               // r2 = 5
        exec(8'h13, 8'h00);               // r3 = 0
        exec(8'h15, 8'hFF);               // r5 = 255
        exec(8'h00, 8'h44, 8'h23);        // divide by zero
        exec(8'h00, 8'h44, 8'h52);        // r4 = 255 / 5
        exec(8'h00, 8'h16, 8'h55);        // add wraps
        exec(8'h00, 8'h26, 8'h35);        // sub underflow
        exec(8'h00, 8'h36, 8'h55);
        exec(8'h00, 8'h56, 8'h52);
        exec(8'h00, 8'h66, 8'h52);
        exec(8'h00, 8'h76, 8'h55);
        exec(8'h25);                      // LED number above four
        exec(8'h33);                      // LED 0 off
        exec(8'h22);                      // LED number above four
        exec(8'h55);                      // blocking sound
        exec(8'h42, 8'h00, 8'h00, 5'h01, 1'b1);
        exec(8'h44, 8'h00, 8'h00, 5'h01, 1'b0);
        exec(8'h01, 8'h72, 8'h00, 5'h00); // input wait, delay 5
        exec(8'h00, 8'h00, 8'h00, 5'h00);
        tick();
        exec(8'h00, 8'h00, 8'h00, 5'h10);
        exec(8'h04, 8'h85, 8'h00, 5'h01, 1'b0, 8'hFE); // limit above 128
        exec(8'h04, 8'h82, 8'h00, 5'h01, 1'b0, 8'h07); // retry
        exec(8'h02, 8'h85);               // load index out of range
        exec(8'h85, 8'h53);               // jump if equal, taken
        exec(8'h95, 8'h24);               // jump if greater, taken

        for (n = 0; n < 424; n++) begin
            if (n == 150) begin
                tx_idle = 73;
                rx_idle = 34;
            end else if (n == 300) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if ($urandom_range(99) < 25) tick();
            else if ($urandom_range(99) < 8) exec({4'h7, 4'($urandom)});
            else random_instr();
        end
        push <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("toy_bytecode_interpreter_step: match");
        end else begin
            $display("toy_bytecode_interpreter_step: mismatch");
        end
        $finish;
    end

endmodule

/* toy_bytecode_interpreter_step.f */
hdl/tbi_pkg.sv
hdl/tbi_front.sv
hdl/tbi_back.sv
hdl/toy_bytecode_interpreter_step.sv
tb/sv/toy_bytecode_interpreter_step_chk.sv
tb/sv/toy_bytecode_interpreter_step_tb.sv
